// ----- sv/qbr_pkg.sv -----
// Package for the quantile binning block: sizes, register indexes and the
// link record passed between neighbouring sort cells.
// No dependencies.
`default_nettype none
package qbr_pkg;
   localparam int MAX_SAMPLES  = 64;
   localparam int MAX_LEVELS   = 7;
   localparam int OUTCOME_BITS = 32;
   localparam int INDEX_BITS   = 16;
   localparam int QUANT_BITS   = 17;
   localparam int LEVEL_BITS   = 3;
   localparam int ADDR_BITS    = $clog2(MAX_SAMPLES);
   localparam int COUNT_BITS   = $clog2(MAX_SAMPLES + 1);
   localparam int CSR_ADDR_BITS = 5;
   localparam int POS_BITS     = COUNT_BITS + QUANT_BITS + 1 - 16;

   localparam logic [QUANT_BITS-1:0] QUANT_ONE = QUANT_BITS'(65536);

   localparam logic [2:0] REG_QCOUNT = 3'd0;
   localparam logic [2:0] REG_Q0     = 3'd1;

   typedef logic signed [OUTCOME_BITS-1:0] key_type;

   typedef struct packed {
      logic    valid;
      logic    gt;
      key_type key;
   } cell_link_type;
endpackage : qbr_pkg
`default_nettype wire

// ----- sv/quantile_bin_relabel.sv -----
// Top level of the quantile binning block: CSR port, sort chain, sample RAM
// and the sequencer. Depends on qbr_pkg, qbr_cell and qbr_ram.
//
// Samples are taken one item per cycle while busy is low. Each accepted item
// is written in load order into a 64-entry RAM and at the same time inserted
// into a row of 64 sort cells, which keep the outcomes in ascending order.
// Samples beyond 64 are dropped and flag the batch as overflowed. The item
// with last set ends the batch and raises busy. For each quantile level in
// use the sequencer then forms, in state ST_POS, the position
// ceil(n*q/65536)-1 with a small multiplier, and in state ST_CUT picks the
// cutoff out of the sort chain and notes whether it repeats an earlier one.
// It then reads the RAM back one sample per cycle and presents one result
// item per cycle on the rsp_ ports, marked by rsp_valid for a single cycle;
// the receiver cannot stall, so results must be taken when shown. Busy stays
// high from the last item on, and the final result is strobed in the last
// cycle that busy is high.
// The class label counts the distinct cutoffs strictly below the outcome.
// Quantile registers should only be written while busy is low.
`default_nettype none
module quantile_bin_relabel (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [qbr_pkg::INDEX_BITS-1:0]        req_sample_index,
   input  wire logic signed [31:0]                    req_outcome,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   output logic [qbr_pkg::INDEX_BITS-1:0]             rsp_result_index,
   output logic [qbr_pkg::LEVEL_BITS-1:0]             rsp_class_label,
   output logic                                       rsp_last_result,
   output logic                                       rsp_overflowed,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [qbr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);
   import qbr_pkg::*;

   localparam int RAM_WIDTH = INDEX_BITS + OUTCOME_BITS;

   typedef enum logic [2:0] {
      ST_LOAD, ST_POS, ST_CUT, ST_EMIT, ST_DRAIN
   } state_type;

   // Configuration registers.
   logic [LEVEL_BITS-1:0] qcount_ff;
   logic [QUANT_BITS-1:0] quant_ff [MAX_LEVELS];
   logic [2:0]            csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff <= '0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            quant_ff[i] <= QUANT_ONE;
         end
      end else if (psel && penable && pwrite) begin
         if (csr_index == REG_QCOUNT) begin
            qcount_ff <= pwdata[LEVEL_BITS-1:0];
         end else begin
            quant_ff[csr_index - REG_Q0] <= pwdata[QUANT_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (csr_index == REG_QCOUNT) begin
         prdata = 32'(qcount_ff);
      end else begin
         prdata = 32'(quant_ff[csr_index - REG_Q0]);
      end
   end

   // Sequencer state.
   state_type             state_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  ovf_ff;
   logic [LEVEL_BITS-1:0] levels_ff;
   logic [LEVEL_BITS-1:0] lvl_ff;
   logic [ADDR_BITS-1:0]  pos_ff;
   key_type               cut_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] uniq_ff;
   logic [COUNT_BITS-1:0] emit_ff;
   logic                  pend_ff;
   logic                  pend_last_ff;

   logic accept;
   logic full;
   logic chain_clear;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_BITS'(MAX_SAMPLES));

   // Sort chain.
   key_type       new_key;
   cell_link_type links [MAX_SAMPLES + 1];

   assign new_key    = req_outcome[OUTCOME_BITS-1:0];
   assign links[0]   = '{valid: 1'b1, gt: 1'b0, key: '0};
   assign chain_clear = (state_ff == ST_DRAIN) && !pend_ff;

   for (genvar c = 0; c < MAX_SAMPLES; c++) begin : g_cell
      qbr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (chain_clear),
         .insert  (accept && !full),
         .new_key (new_key),
         .left    (links[c]),
         .link    (links[c + 1])
      );
   end

   // Sample RAM, load order.
   logic [RAM_WIDTH-1:0] ram_rd;

   qbr_ram #(.WIDTH(RAM_WIDTH), .DEPTH(MAX_SAMPLES)) u_ram (
      .clock   (clock),
      .wr_en   (accept && !full),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data ({req_sample_index, new_key}),
      .rd_addr (emit_ff[ADDR_BITS-1:0]),
      .rd_data (ram_rd)
   );

   // Position of the current level: ceil(n*q/65536)-1, clamped to [0, n-1].
   logic [COUNT_BITS+QUANT_BITS-1:0] prod;
   logic [COUNT_BITS+QUANT_BITS:0]   rounded;
   logic [POS_BITS-1:0]              up;
   logic [POS_BITS-1:0]              pos_raw;
   logic [ADDR_BITS-1:0]             pos_in;

   always_comb begin
      prod    = count_ff * quant_ff[lvl_ff];
      rounded = (COUNT_BITS+QUANT_BITS+1)'(prod) + (COUNT_BITS+QUANT_BITS+1)'(65535);
      up      = rounded[COUNT_BITS+QUANT_BITS:16];
      pos_raw = (up == '0) ? '0 : up - 1'b1;
      if (pos_raw >= POS_BITS'(count_ff)) begin
         pos_in = ADDR_BITS'(count_ff - 1'b1);
      end else begin
         pos_in = pos_raw[ADDR_BITS-1:0];
      end
   end

   // Cutoff pick and repeat check against the cutoffs taken so far.
   key_type pick;
   logic    repeat_hit;

   always_comb begin
      pick       = links[COUNT_BITS'(pos_ff) + COUNT_BITS'(1)].key;
      repeat_hit = 1'b0;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         if ((LEVEL_BITS'(j) < lvl_ff) && (cut_ff[j] == pick)) begin
            repeat_hit = 1'b1;
         end
      end
   end

   // Label of the sample read back from the RAM.
   key_type               rd_key;
   logic [MAX_LEVELS-1:0] below;

   assign rd_key = ram_rd[OUTCOME_BITS-1:0];

   always_comb begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         below[j] = uniq_ff[j] && (cut_ff[j] < rd_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         levels_ff <= '0;
         lvl_ff    <= '0;
         uniq_ff   <= '0;
         emit_ff   <= '0;
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid    <= pend_ff;
         if (pend_ff) begin
            rsp_result_index <= ram_rd[RAM_WIDTH-1:OUTCOME_BITS];
            rsp_class_label  <= LEVEL_BITS'($countones(below));
            rsp_last_result  <= pend_last_ff;
            rsp_overflowed   <= ovf_ff;
         end
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (req_last) begin
                     levels_ff <= (32'(qcount_ff) > MAX_LEVELS) ?
                                  LEVEL_BITS'(MAX_LEVELS) : qcount_ff;
                     lvl_ff    <= '0;
                     uniq_ff   <= '0;
                     emit_ff   <= '0;
                     state_ff  <= (qcount_ff == '0) ? ST_EMIT : ST_POS;
                  end
               end
            end
            ST_POS: begin
               pos_ff   <= pos_in;
               state_ff <= ST_CUT;
            end
            ST_CUT: begin
               cut_ff[lvl_ff]  <= pick;
               uniq_ff[lvl_ff] <= !repeat_hit;
               lvl_ff          <= lvl_ff + 1'b1;
               state_ff        <= (lvl_ff + 1'b1 == levels_ff) ? ST_EMIT : ST_POS;
            end
            ST_EMIT: begin
               pend_ff      <= 1'b1;
               pend_last_ff <= (emit_ff + 1'b1 == count_ff);
               emit_ff      <= emit_ff + 1'b1;
               if (emit_ff + 1'b1 == count_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!pend_ff) begin
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end
endmodule : quantile_bin_relabel
`default_nettype wire

// ----- sv/qbr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module qbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule : qbr_ram
`default_nettype wire

// ----- sv/qbr_cell.sv -----
// One cell of the insertion sort chain: holds one key, ascending along the row.
// Depends on qbr_pkg.
`default_nettype none
module qbr_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   clear,
   input  wire logic                   insert,
   input  wire qbr_pkg::key_type       new_key,
   input  wire qbr_pkg::cell_link_type left,
   output qbr_pkg::cell_link_type      link
);
   import qbr_pkg::*;

   logic    valid_ff;
   key_type key_ff;

   assign link.valid = valid_ff;
   assign link.gt    = valid_ff && (key_ff > new_key);
   assign link.key   = key_ff;

   // A larger key to the left shifts in; otherwise this cell takes the new
   // key if it is the first one larger than it, or the first empty one.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (insert && left.valid) begin
         valid_ff <= 1'b1;
      end
      if (insert && left.valid) begin
         if (left.gt) begin
            key_ff <= left.key;
         end else if (link.gt || !valid_ff) begin
            key_ff <= new_key;
         end
      end
   end
endmodule : qbr_cell
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for quantile_bin_relabel: drives sample batches and
// quantile settings, predicts every labelled result and compares it.
// Depends on qbr_pkg and the quantile_bin_relabel RTL.
`default_nettype none

typedef struct {
   logic [15:0] index;
   logic [2:0]  label;
   logic        last_flag;
   logic        ovf;
} label_rec_type;

// Scoreboard: keeps its own copy of the quantile registers and the batch
// under way, and predicts the labels when a batch closes.
class qbr_scoreboard;
   logic [2:0]          level_count;
   logic [16:0]         level [7];
   logic signed [31:0]  held_outcome [$];
   logic [15:0]         held_index [$];
   bit                  dropped;
   label_rec_type       pending_labels [$];
   int                  mismatches;

   function new();
      level_count = 3'd0;
      foreach (level[i]) level[i] = 17'd65536;
      dropped = 0;
      mismatches = 0;
   endfunction

   function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == qbr_pkg::REG_QCOUNT) level_count = value[2:0];
      else if (idx <= 7) level[idx - 1] = value[16:0];
   endfunction

   static function void sort_keys(ref logic signed [31:0] a [64], input int n);
      logic signed [31:0] x;
      int j;
      for (int i = 1; i < n; i++) begin
         x = a[i];
         j = i;
         while (j > 0 && a[j-1] > x) begin
            a[j] = a[j-1];
            j--;
         end
         a[j] = x;
      end
   endfunction

   // Notes one accepted sample; a sample with last set closes the batch and
   // queues one expected label per stored sample.
   function void note_sample(logic [15:0] idx, logic signed [31:0] outc, logic last);
      logic signed [31:0] sorted [64];
      logic signed [31:0] cuts [64];
      logic signed [31:0] uniq [7];
      int n, levels, k, lab;
      longint unsigned up, pos;
      label_rec_type r;
      if (held_outcome.size() < qbr_pkg::MAX_SAMPLES) begin
         held_outcome = {held_outcome, outc};
         held_index = {held_index, idx};
      end else begin
         dropped = 1;
      end
      if (!last) return;
      n = held_outcome.size();
      levels = level_count;
      for (int i = 0; i < n; i++) sorted[i] = held_outcome[i];
      sort_keys(sorted, n);
      for (int i = 0; i < levels; i++) begin
         up = (longint'(n) * level[i] + 65535) >> 16;
         pos = (up == 0) ? 0 : up - 1;
         if (pos >= n) pos = n - 1;
         cuts[i] = sorted[pos];
      end
      // Levels need not be ascending, so the cutoffs are ordered before
      // repeats are merged.
      sort_keys(cuts, levels);
      k = 0;
      for (int i = 0; i < levels; i++)
         if (k == 0 || uniq[k-1] != cuts[i]) begin
            uniq[k] = cuts[i];
            k++;
         end
      for (int i = 0; i < n; i++) begin
         lab = 0;
         for (int j = 0; j < k; j++) if (uniq[j] < held_outcome[i]) lab++;
         r.index = held_index[i];
         r.label = lab[2:0];
         r.last_flag = (i == n - 1);
         r.ovf = dropped;
         pending_labels = {pending_labels, r};
      end
      held_outcome.delete();
      held_index.delete();
      dropped = 0;
   endfunction

   function void check_label(logic [15:0] idx, logic [2:0] lab, logic lst, logic ovf);
      label_rec_type e;
      if (pending_labels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: index %0d label %0d last %0d ovf %0d",
                     idx, lab, lst, ovf);
         return;
      end
      e = pending_labels.pop_front();
      if (idx !== e.index || lab !== e.label || lst !== e.last_flag || ovf !== e.ovf) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected index %0d label %0d last %0d ovf %0d, got %0d %0d %0d %0d",
                     e.index, e.label, e.last_flag, e.ovf, idx, lab, lst, ovf);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [15:0] req_sample_index = '0;
   logic signed [31:0] req_outcome = '0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic [15:0] rsp_result_index;
   logic [2:0]  rsp_class_label;
   logic        rsp_last_result;
   logic        rsp_overflowed;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [qbr_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   qbr_scoreboard labels_sb;
   int          items_sent;

   quantile_bin_relabel DUT (.*);

   always #1 clock = ~clock;

   // The receiver cannot stall, so every strobed result is checked at the
   // rising edge that ends its cycle.
   always @(posedge clock)
      if (!reset && rsp_valid)
         labels_sb.check_label(rsp_result_index, rsp_class_label, rsp_last_result,
                               rsp_overflowed);

   // Generous guard: a stuck handshake ends the run as a failure.
   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Gap between items: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Register write: setup cycle, then access cycle; pready is always high.
   task automatic write_reg(int unsigned idx, logic [31:0] value);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0;
      paddr = qbr_pkg::CSR_ADDR_BITS'(idx * 4);
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      labels_sb.write_reg(idx, value);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Presents one sample and holds it until the block takes it.
   task automatic send_sample(logic [15:0] idx, logic signed [31:0] outc, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1;
      req_sample_index = idx;
      req_outcome = outc;
      req_last = last;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      labels_sb.note_sample(idx, outc, last);
      items_sent++;
      @(negedge clock);
      start = 0;
      req_last = 0;
   endtask

   // Before any register write the batch must be fully labelled and the
   // sequencer back at rest.
   task automatic wait_idle();
      while (labels_sb.pending_labels.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_outcome();
      case ($urandom_range(3))
         0: return $urandom_range(6);                      // many ties
         1: return $signed($urandom_range(6)) - 3;
         2: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_levels();
      write_reg(qbr_pkg::REG_QCOUNT, $urandom_range(7));
      for (int i = 0; i < 7; i++) begin
         case ($urandom_range(5))
            0: write_reg(qbr_pkg::REG_Q0 + i, 0);
            1: write_reg(qbr_pkg::REG_Q0 + i, 65536);
            2: write_reg(qbr_pkg::REG_Q0 + i, $urandom_range(131071, 65537));
            3: write_reg(qbr_pkg::REG_Q0 + i, $urandom);   // upper bits are masked
            default: write_reg(qbr_pkg::REG_Q0 + i, $urandom_range(65536, 1));
         endcase
      end
   endtask

   task automatic send_batch(int len);
      for (int i = 0; i < len; i++)
         send_sample(16'($urandom), pick_outcome(), i == len - 1);
   endtask

   initial begin
      int len, r;
      labels_sb = new();
      items_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // No levels in use after reset: a single sample and then a small batch
      // all carry label zero.
      send_sample(16'd0, 32'sh80000000, 1'b1);
      send_sample(16'hFFFF, 32'sh7FFFFFFF, 1'b0);
      send_sample(16'h1234, 32'sd0, 1'b1);
      wait_idle();

      // Every level in use, out of order, with zero, one and above-one
      // levels and repeated cutoffs.
      write_reg(qbr_pkg::REG_QCOUNT, 7);
      write_reg(qbr_pkg::REG_Q0 + 0, 0);
      write_reg(qbr_pkg::REG_Q0 + 1, 65536);
      write_reg(qbr_pkg::REG_Q0 + 2, 1);
      write_reg(qbr_pkg::REG_Q0 + 3, 131071);
      write_reg(qbr_pkg::REG_Q0 + 4, 32768);
      write_reg(qbr_pkg::REG_Q0 + 5, 65535);
      write_reg(qbr_pkg::REG_Q0 + 6, 21845);
      send_sample(16'd7, 32'sh7FFFFFFF, 1'b0);
      send_sample(16'd8, 32'sh80000000, 1'b0);
      send_sample(16'd9, -32'sd1, 1'b0);
      send_sample(16'd10, 32'sd0, 1'b0);
      send_sample(16'd11, 32'sd0, 1'b0);
      send_sample(16'd12, 32'sd1, 1'b0);
      send_sample(16'hFFFF, 32'sh00010000, 1'b1);
      wait_idle();

      // Ascending levels over a batch that is all ties.
      write_reg(qbr_pkg::REG_QCOUNT, 3);
      write_reg(qbr_pkg::REG_Q0 + 0, 16384);
      write_reg(qbr_pkg::REG_Q0 + 1, 32768);
      write_reg(qbr_pkg::REG_Q0 + 2, 49152);
      for (int i = 0; i < 5; i++) send_sample(16'(i), 32'sd5, i == 4);
      wait_idle();

      // Random batches: mostly short, some long, a few past capacity so that
      // samples are dropped, including the final one of a batch.
      while (items_sent < 160) begin
         if ($urandom_range(2) == 0) begin
            wait_idle();
            random_levels();
         end
         r = $urandom_range(99);
         if (r < 85) len = $urandom_range(12, 1);
         else if (r < 95) len = $urandom_range(64, 20);
         else len = $urandom_range(70, 65);
         send_batch(len);
      end

      for (int c = 0; c < 20000 && labels_sb.pending_labels.size() != 0; c++)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (labels_sb.mismatches == 0 && labels_sb.pending_labels.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
